>>> src/odmr_pma_pkg.sv
// Package: shared types, constants and helpers of the ODMR pixel moment accumulator.
package odmr_pma_pkg;

    localparam logic [31:0] BIAS = 32'h8000_0000;

    // Ratio divider: 63-bit dividend, one quotient bit per stage.
    localparam int unsigned RATIO_W      = 63;
    localparam int unsigned RATIO_STAGES = RATIO_W;
    // Scaled-term divider: 96-bit dividend over the 31-bit scale.
    localparam int unsigned TERM_W       = 96;
    localparam int unsigned TERM_STAGES  = TERM_W;
    localparam int unsigned MOM_STAGES   = 6;

    localparam logic [1:0] METHOD_COG      = 2'd0;
    localparam logic [1:0] METHOD_SECOND   = 2'd1;
    localparam logic [1:0] METHOD_MEAN_DEV = 2'd2;
    localparam logic [1:0] METHOD_SPLIT    = 2'd3;

    localparam logic [2:0] CFG_CONTRAST_SCALE     = 3'd0;
    localparam logic [2:0] CFG_FREQ_INDEX         = 3'd1;
    localparam logic [2:0] CFG_FREQ_OFFSET_SQUARE = 3'd2;
    localparam logic [2:0] CFG_METHOD             = 3'd3;
    localparam logic [2:0] CFG_EARLIER_PASS_VALID = 3'd4;

    typedef struct packed {
        logic [31:0] on_count;
        logic [31:0] off_count;
        logic [31:0] sum_contrast;
        logic [31:0] sum_first_moment;
        logic [31:0] sum_third;
        logic [31:0] sum_fourth;
        logic [31:0] prior_contrast;
        logic [31:0] prior_first_moment;
        logic [31:0] prior_mean_dev;
    } pixel_t;

    typedef struct packed {
        logic [30:0] contrast_scale;
        logic [15:0] freq_index;
        logic [30:0] freq_offset_square;
        logic [1:0]  method;
        logic        earlier_pass_valid;
    } cfg_t;

    // Side data that rides along the ratio divider.
    typedef struct packed {
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
        logic [31:0] mean_dev;   // prior_mean_dev - BIAS, two's complement
        logic [46:0] weight;     // freq_index * scale
        logic        off_zero;
        logic        g_neg;
        logic        p_zero;
        logic [31:0] off_div;
        logic [31:0] p_div;
    } div_side_t;

    typedef struct packed {
        logic [RATIO_W-1:0] q_ratio;
        logic [RATIO_W-1:0] q_cog;
        div_side_t          side;
    } ratio_t;

    typedef struct packed {
        logic [31:0] s0n;
        logic [31:0] s1n;
        logic [31:0] s2;
        logic [31:0] s3;
        logic [31:0] s2m1;       // second-moment update of sum three
        logic        dneg;
    } acc_t;

    typedef struct packed {
        logic [TERM_W-1:0] num_third;
        logic [TERM_W-1:0] num_fourth;
        acc_t              acc;
    } prod_t;

    typedef struct packed {
        logic [31:0] new_sum_contrast;
        logic [31:0] new_sum_first_moment;
        logic [31:0] new_sum_third;
        logic [31:0] new_sum_fourth;
        logic [31:0] peak_deviation;
    } result_t;

    function automatic logic [31:0] bias_dist(logic [31:0] v);
        logic [31:0] x;
        x = v - BIAS;
        return x[31] ? (32'd0 - x) : x;
    endfunction

endpackage

>>> src/odmr_pma_contrast.sv
// Product stage and the two restoring dividers (contrast ratio, centre of gravity).
module odmr_pma_contrast (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  odmr_pma_pkg::pixel_t in_pix,
    input  odmr_pma_pkg::cfg_t   cfg,
    output logic                 out_valid,
    output odmr_pma_pkg::ratio_t out_ratio
);
    import odmr_pma_pkg::*;

    logic [RATIO_STAGES:0] vld_reg;
    logic [31:0]           r1_reg  [0:RATIO_STAGES];
    logic [31:0]           r1_next [0:RATIO_STAGES];
    logic [RATIO_W-1:0]    n1_reg  [0:RATIO_STAGES];
    logic [RATIO_W-1:0]    n1_next [0:RATIO_STAGES];
    logic [31:0]           r2_reg  [0:RATIO_STAGES];
    logic [31:0]           r2_next [0:RATIO_STAGES];
    logic [RATIO_W-1:0]    n2_reg  [0:RATIO_STAGES];
    logic [RATIO_W-1:0]    n2_next [0:RATIO_STAGES];
    div_side_t             side_reg  [0:RATIO_STAGES];
    div_side_t             side_next [0:RATIO_STAGES];

    always_comb
    begin
        logic [31:0] fu;
        logic [31:0] pu;
        logic [31:0] f_mag;
        logic [32:0] t1;
        logic [32:0] t2;
        logic        ge1;
        logic        ge2;
        fu = in_pix.prior_first_moment - BIAS;
        pu = in_pix.prior_contrast - BIAS;
        f_mag = fu[31] ? (32'd0 - fu) : fu;

        // entry stage: products, dividends loaded with zero remainder
        r1_next[0] = '0;
        r2_next[0] = '0;
        n1_next[0] = RATIO_W'(in_pix.on_count) * RATIO_W'(cfg.contrast_scale);
        n2_next[0] = RATIO_W'(f_mag) * RATIO_W'(cfg.contrast_scale);
        side_next[0].s0       = in_pix.sum_contrast;
        side_next[0].s1       = in_pix.sum_first_moment;
        side_next[0].s2       = in_pix.sum_third;
        side_next[0].s3       = in_pix.sum_fourth;
        side_next[0].mean_dev = in_pix.prior_mean_dev - BIAS;
        side_next[0].weight   = 47'(cfg.freq_index) * 47'(cfg.contrast_scale);
        side_next[0].off_zero = (in_pix.off_count == 32'd0);
        side_next[0].g_neg    = fu[31] ^ pu[31];
        side_next[0].p_zero   = (pu == 32'd0);
        side_next[0].off_div  = in_pix.off_count;
        side_next[0].p_div    = pu[31] ? (32'd0 - pu) : pu;

        // one quotient bit per stage, MSB first
        for (int k = 0; k < RATIO_STAGES; k++)
        begin
            t1  = {r1_reg[k], n1_reg[k][RATIO_W-1]};
            ge1 = (t1 >= {1'b0, side_reg[k].off_div});
            r1_next[k+1] = ge1 ? 32'(t1 - {1'b0, side_reg[k].off_div}) : t1[31:0];
            n1_next[k+1] = {n1_reg[k][RATIO_W-2:0], ge1};
            t2  = {r2_reg[k], n2_reg[k][RATIO_W-1]};
            ge2 = (t2 >= {1'b0, side_reg[k].p_div});
            r2_next[k+1] = ge2 ? 32'(t2 - {1'b0, side_reg[k].p_div}) : t2[31:0];
            n2_next[k+1] = {n2_reg[k][RATIO_W-2:0], ge2};
            side_next[k+1] = side_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[RATIO_STAGES-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= RATIO_STAGES; k++)
            begin
                r1_reg[k]   <= r1_next[k];
                n1_reg[k]   <= n1_next[k];
                r2_reg[k]   <= r2_next[k];
                n2_reg[k]   <= n2_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid         = vld_reg[RATIO_STAGES];
    assign out_ratio.q_ratio = n1_reg[RATIO_STAGES];
    assign out_ratio.q_cog   = n2_reg[RATIO_STAGES];
    assign out_ratio.side    = side_reg[RATIO_STAGES];

endmodule

>>> src/odmr_pma_moment.sv
// Contrast, deviation terms, sum updates and the wide deviation-by-contrast products.
module odmr_pma_moment (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  odmr_pma_pkg::ratio_t in_ratio,
    input  odmr_pma_pkg::cfg_t   cfg,
    output logic                 out_valid,
    output odmr_pma_pkg::prod_t  out_prod
);
    import odmr_pma_pkg::*;

    typedef struct packed {
        logic [31:0] d;
        logic [63:0] g;
        logic [63:0] diff;
        logic [63:0] dev;
        logic [63:0] sp;
        logic [31:0] dm;
        logic        dneg;
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
        logic [31:0] s2m1;
        logic [31:0] fd;
        logic [31:0] fsqd;
        logic [31:0] mean_dev;
        logic [46:0] weight;
        logic [63:0] pp_dev_lo;
        logic [63:0] pp_dev_hi;
        logic [63:0] pp_sp_lo;
        logic [63:0] pp_sp_hi;
        logic [TERM_W-1:0] n3;
        logic [TERM_W-1:0] n4;
    } mom_t;

    logic [MOM_STAGES-1:0] vld_reg;
    mom_t                  st_reg  [0:MOM_STAGES-1];
    mom_t                  st_next [0:MOM_STAGES-1];

    always_comb
    begin
        logic [63:0] qg;
        logic [64:0] spd;
        qg = 64'(in_ratio.q_cog);

        // contrast and centre of gravity
        st_next[0]          = '0;
        st_next[0].d        = in_ratio.side.off_zero ? 32'(in_ratio.side.off_zero ?
                              {1'b0, cfg.contrast_scale} : 32'd0)
                            : 32'(in_ratio.q_ratio) - {1'b0, cfg.contrast_scale};
        st_next[0].g        = in_ratio.side.p_zero ? 64'd0 :
                              (in_ratio.side.g_neg ? (64'd0 - qg) : qg);
        st_next[0].s0       = in_ratio.side.s0;
        st_next[0].s1       = in_ratio.side.s1;
        st_next[0].s2       = in_ratio.side.s2;
        st_next[0].s3       = in_ratio.side.s3;
        st_next[0].mean_dev = in_ratio.side.mean_dev;
        st_next[0].weight   = in_ratio.side.weight;

        // offset from centre, first sum, weighted contrasts
        st_next[1]      = st_reg[0];
        st_next[1].diff = 64'(st_reg[0].weight) - st_reg[0].g;
        st_next[1].s0   = st_reg[0].s0 + st_reg[0].d;
        st_next[1].fd   = 32'(32'(cfg.freq_index) * st_reg[0].d);
        st_next[1].fsqd = 32'(32'(cfg.freq_offset_square) * st_reg[0].d);
        st_next[1].dneg = st_reg[0].d[31];
        st_next[1].dm   = st_reg[0].d[31] ? (32'd0 - st_reg[0].d) : st_reg[0].d;

        st_next[2]      = st_reg[1];
        st_next[2].dev  = st_reg[1].diff[63] ? (64'd0 - st_reg[1].diff) : st_reg[1].diff;
        st_next[2].s1   = st_reg[1].s1 + st_reg[1].fd;
        st_next[2].s2m1 = st_reg[1].s2 + st_reg[1].fsqd;

        // split deviation |dev - M|
        spd           = {1'b0, st_reg[2].dev} - {{33{st_reg[2].mean_dev[31]}},
                        st_reg[2].mean_dev};
        st_next[3]    = st_reg[2];
        st_next[3].sp = spd[64] ? 64'(65'd0 - spd) : spd[63:0];

        // 32x32 partial products
        st_next[4]           = st_reg[3];
        st_next[4].pp_dev_lo = 64'(st_reg[3].dev[31:0]) * 64'(st_reg[3].dm);
        st_next[4].pp_dev_hi = 64'(st_reg[3].dev[63:32]) * 64'(st_reg[3].dm);
        st_next[4].pp_sp_lo  = 64'(st_reg[3].sp[31:0]) * 64'(st_reg[3].dm);
        st_next[4].pp_sp_hi  = 64'(st_reg[3].sp[63:32]) * 64'(st_reg[3].dm);

        st_next[5]    = st_reg[4];
        st_next[5].n3 = TERM_W'(st_reg[4].pp_dev_lo) + {st_reg[4].pp_dev_hi, 32'd0};
        st_next[5].n4 = TERM_W'(st_reg[4].pp_sp_lo) + {st_reg[4].pp_sp_hi, 32'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[MOM_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < MOM_STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid           = vld_reg[MOM_STAGES-1];
    assign out_prod.num_third  = st_reg[MOM_STAGES-1].n3;
    assign out_prod.num_fourth = st_reg[MOM_STAGES-1].n4;
    assign out_prod.acc.s0n    = st_reg[MOM_STAGES-1].s0;
    assign out_prod.acc.s1n    = st_reg[MOM_STAGES-1].s1;
    assign out_prod.acc.s2     = st_reg[MOM_STAGES-1].s2;
    assign out_prod.acc.s3     = st_reg[MOM_STAGES-1].s3;
    assign out_prod.acc.s2m1   = st_reg[MOM_STAGES-1].s2m1;
    assign out_prod.acc.dneg   = st_reg[MOM_STAGES-1].dneg;

endmodule

>>> src/odmr_pma_scale.sv
// Division of the deviation products by the scale, method select and peak deviation.
module odmr_pma_scale (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  odmr_pma_pkg::prod_t   in_prod,
    input  odmr_pma_pkg::cfg_t    cfg,
    output logic                  out_valid,
    output odmr_pma_pkg::result_t out_res
);
    import odmr_pma_pkg::*;

    logic [TERM_STAGES+2:0] vld_reg;
    logic [30:0]       r3_reg  [0:TERM_STAGES-1];
    logic [30:0]       r3_next [0:TERM_STAGES-1];
    logic [TERM_W-1:0] n3_reg  [0:TERM_STAGES-1];
    logic [TERM_W-1:0] n3_next [0:TERM_STAGES-1];
    logic [30:0]       r4_reg  [0:TERM_STAGES-1];
    logic [30:0]       r4_next [0:TERM_STAGES-1];
    logic [TERM_W-1:0] n4_reg  [0:TERM_STAGES-1];
    logic [TERM_W-1:0] n4_next [0:TERM_STAGES-1];
    acc_t              acc_reg  [0:TERM_STAGES-1];
    acc_t              acc_next [0:TERM_STAGES-1];

    result_t sel_reg;
    result_t sel_next;
    logic    use3_reg;
    logic    use4_reg;
    logic    use3_next;
    logic    use4_next;
    result_t dst_reg;
    result_t dst_next;
    logic [31:0] dist1_reg;
    logic [31:0] dist3_reg;
    logic [31:0] dist4_reg;
    result_t res_reg;
    result_t res_next;

    always_comb
    begin
        logic [31:0] t3;
        logic [31:0] t4;
        logic        ge3;
        logic        ge4;
        for (int k = 0; k < TERM_STAGES; k++)
        begin
            if (k == 0)
            begin
                t3 = {31'd0, in_prod.num_third[TERM_W-1]};
                t4 = {31'd0, in_prod.num_fourth[TERM_W-1]};
                ge3 = (t3 >= {1'b0, cfg.contrast_scale});
                ge4 = (t4 >= {1'b0, cfg.contrast_scale});
                n3_next[k] = {in_prod.num_third[TERM_W-2:0], ge3};
                n4_next[k] = {in_prod.num_fourth[TERM_W-2:0], ge4};
                acc_next[k] = in_prod.acc;
            end
            else
            begin
                t3 = {r3_reg[k-1], n3_reg[k-1][TERM_W-1]};
                t4 = {r4_reg[k-1], n4_reg[k-1][TERM_W-1]};
                ge3 = (t3 >= {1'b0, cfg.contrast_scale});
                ge4 = (t4 >= {1'b0, cfg.contrast_scale});
                n3_next[k] = {n3_reg[k-1][TERM_W-2:0], ge3};
                n4_next[k] = {n4_reg[k-1][TERM_W-2:0], ge4};
                acc_next[k] = acc_reg[k-1];
            end
            r3_next[k] = ge3 ? 31'(t3 - {1'b0, cfg.contrast_scale}) : t3[30:0];
            r4_next[k] = ge4 ? 31'(t4 - {1'b0, cfg.contrast_scale}) : t4[30:0];
        end
    end

    // sign, sum updates and method select
    always_comb
    begin
        logic [31:0] q3;
        logic [31:0] q4;
        logic [31:0] term3;
        logic [31:0] term4;
        acc_t        a;
        a  = acc_reg[TERM_STAGES-1];
        q3 = n3_reg[TERM_STAGES-1][31:0];
        q4 = n4_reg[TERM_STAGES-1][31:0];
        if (cfg.contrast_scale == 31'd0)
        begin
            term3 = 32'd0;
            term4 = 32'd0;
        end
        else
        begin
            term3 = a.dneg ? (32'd0 - q3) : q3;
            term4 = a.dneg ? (32'd0 - q4) : q4;
        end
        sel_next.new_sum_contrast     = a.s0n;
        sel_next.new_sum_first_moment = a.s1n;
        sel_next.new_sum_third        = a.s2;
        sel_next.new_sum_fourth       = a.s3;
        sel_next.peak_deviation       = 32'd0;
        use3_next = 1'b0;
        use4_next = 1'b0;
        case (cfg.method)
            METHOD_SECOND:
            begin
                sel_next.new_sum_third = a.s2m1;
                use3_next = 1'b1;
            end
            METHOD_MEAN_DEV, METHOD_SPLIT:
            begin
                if (cfg.earlier_pass_valid)
                begin
                    sel_next.new_sum_third = a.s2 + term3;
                    use3_next = 1'b1;
                    if (cfg.method == METHOD_SPLIT)
                    begin
                        sel_next.new_sum_fourth = a.s3 + term4;
                        use4_next = 1'b1;
                    end
                end
            end
            default:
            begin
                use3_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        dst_next = sel_reg;
    end

    always_comb
    begin
        logic [31:0] m;
        m = dist1_reg;
        if (dist3_reg > m)
        begin
            m = dist3_reg;
        end
        if (dist4_reg > m)
        begin
            m = dist4_reg;
        end
        res_next = dst_reg;
        res_next.peak_deviation = m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TERM_STAGES+1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < TERM_STAGES; k++)
            begin
                r3_reg[k]  <= r3_next[k];
                n3_reg[k]  <= n3_next[k];
                r4_reg[k]  <= r4_next[k];
                n4_reg[k]  <= n4_next[k];
                acc_reg[k] <= acc_next[k];
            end
            sel_reg   <= sel_next;
            use3_reg  <= use3_next;
            use4_reg  <= use4_next;
            dst_reg   <= dst_next;
            dist1_reg <= bias_dist(sel_reg.new_sum_first_moment);
            dist3_reg <= use3_reg ? bias_dist(sel_reg.new_sum_third) : 32'd0;
            dist4_reg <= use4_reg ? bias_dist(sel_reg.new_sum_fourth) : 32'd0;
            res_reg   <= res_next;
        end
    end

    assign out_valid = vld_reg[TERM_STAGES+2];
    assign out_res   = res_reg;

endmodule

>>> src/odmr_pixel_moment_accumulate.sv
// Top level: configuration registers, pixel pipeline and output skid buffer.
//
// One pixel per clock in while s_tready is high, one result per pixel out, in order.
// The pipeline has one product stage and 63 stages of the contrast-ratio and
// centre-of-gravity dividers (one quotient bit each), six stages for contrast,
// deviations and the 64x32 deviation products, 96 stages of the divide-by-scale for
// the method terms, and three stages for method select and peak deviation. The whole
// pipeline moves on one enable; a one-entry skid buffer at the output takes a result
// when the downstream side stalls, and s_tready drops only while that buffer is full.
// Configuration writes take effect at once and must only be made with the
// pipeline empty.
module odmr_pixel_moment_accumulate (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // on_count, off_count, sum_contrast, sum_first_moment, sum_third, sum_fourth,
    // prior_contrast, prior_first_moment, prior_mean_dev (32 bits each, lowest first)
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_sum_contrast, new_sum_first_moment, new_sum_third, new_sum_fourth,
    // peak_deviation (32 bits each, lowest first)
    output logic [159:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_wdata
);
    import odmr_pma_pkg::*;

    cfg_t    cfg_reg;
    pixel_t  pix;
    logic    en;
    logic    ratio_valid;
    ratio_t  ratio;
    logic    prod_valid;
    prod_t   prod;
    logic    pipe_valid;
    result_t pipe_res;
    logic    skid_full_reg;
    result_t skid_reg;
    result_t out_res;

    // register file; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.contrast_scale     <= 31'd1;
            cfg_reg.freq_index         <= '0;
            cfg_reg.freq_offset_square <= '0;
            cfg_reg.method             <= METHOD_COG;
            cfg_reg.earlier_pass_valid <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CONTRAST_SCALE:     cfg_reg.contrast_scale     <= cfg_wdata;
                CFG_FREQ_INDEX:         cfg_reg.freq_index         <= cfg_wdata[15:0];
                CFG_FREQ_OFFSET_SQUARE: cfg_reg.freq_offset_square <= cfg_wdata;
                CFG_METHOD:             cfg_reg.method             <= cfg_wdata[1:0];
                CFG_EARLIER_PASS_VALID: cfg_reg.earlier_pass_valid <= cfg_wdata[0];
                default:                cfg_reg.method             <= cfg_reg.method;
            endcase
        end
    end

    assign pix.on_count           = s_tdata[31:0];
    assign pix.off_count          = s_tdata[63:32];
    assign pix.sum_contrast       = s_tdata[95:64];
    assign pix.sum_first_moment   = s_tdata[127:96];
    assign pix.sum_third          = s_tdata[159:128];
    assign pix.sum_fourth         = s_tdata[191:160];
    assign pix.prior_contrast     = s_tdata[223:192];
    assign pix.prior_first_moment = s_tdata[255:224];
    assign pix.prior_mean_dev     = s_tdata[287:256];

    // pipeline advances whenever the skid buffer can absorb the last stage
    assign en       = !skid_full_reg;
    assign s_tready = en;

    odmr_pma_contrast u_contrast (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_pix    (pix),
        .cfg       (cfg_reg),
        .out_valid (ratio_valid),
        .out_ratio (ratio)
    );

    odmr_pma_moment u_moment (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ratio_valid),
        .in_ratio  (ratio),
        .cfg       (cfg_reg),
        .out_valid (prod_valid),
        .out_prod  (prod)
    );

    odmr_pma_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prod_valid),
        .in_prod   (prod),
        .cfg       (cfg_reg),
        .out_valid (pipe_valid),
        .out_res   (pipe_res)
    );

    // skid: catch the result the pipeline would otherwise push past a stalled sink
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg && m_tready)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (!skid_full_reg && pipe_valid && !m_tready)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_reg <= pipe_res;
        end
    end

    assign out_res  = skid_full_reg ? skid_reg : pipe_res;
    assign m_tvalid = skid_full_reg || pipe_valid;
    assign m_tdata  = {out_res.peak_deviation, out_res.new_sum_fourth,
                       out_res.new_sum_third, out_res.new_sum_first_moment,
                       out_res.new_sum_contrast};

endmodule

>>> src/odmr_pma_checker.sv
// Port-level assertions of the pixel moment accumulator and their bind.
module odmr_pma_props (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata
);

    // the first reset edge clears the valid bits, so check from the second one on
    a_reset_quiet: assert property (@(posedge clk) !rst_n ##1 !rst_n |-> !m_tvalid)
        else $error("result request during reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result request changed while stalled");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[159:128] <= 32'h8000_0000))
        else $error("peak deviation above 2^31");

endmodule

bind odmr_pixel_moment_accumulate odmr_pma_props u_odmr_pma_props (.*);

>>> tb/odmr_pma_checker.sv
// Checker: tracks configuration writes, predicts pixel sums and compares results.
`timescale 1ns / 100ps
module odmr_pma_checker
    import odmr_pma_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [159:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_wdata,
    output int           errors,
    output int           pending
);

    localparam int EXP_DEPTH = 4096;

    cfg_t    shadow_cfg;
    result_t exp_mem [EXP_DEPTH];
    int      wr_cnt = 0;
    int      rd_cnt = 0;

    // |signed(v - BIAS)|, 2^31 for the most negative value
    function automatic logic [31:0] offset_mag(logic [31:0] v);
        logic [31:0] x;
        x = v - BIAS;
        return x[31] ? (32'd0 - x) : x;
    endfunction

    // trunc(mag * signed(dbits) / c) wrapped to 32 bits
    function automatic logic [31:0] weighted_term(logic [63:0] mag, logic [31:0] dbits,
                                                  logic [31:0] c);
        logic [127:0] num;
        logic [31:0]  dm;
        logic [31:0]  q;
        if (c == 32'd0)
            return 32'd0;
        dm  = dbits[31] ? (32'd0 - dbits) : dbits;
        num = {64'd0, mag} * {96'd0, dm};
        q   = 32'(num / {96'd0, c});
        return dbits[31] ? (32'd0 - q) : q;
    endfunction

    function automatic longint unbiased(logic [31:0] v);
        return longint'({32'd0, v}) - 64'sd2147483648;
    endfunction

    function automatic result_t predict_sums(logic [287:0] raw);
        logic [31:0] fld [9];
        logic [31:0] c, d, fidx, s2, s3, peak, dv;
        logic [63:0] quot, dev, split;
        longint      p, f, m, g, a;
        result_t     r;
        for (int i = 0; i < 9; i++)
            fld[i] = raw[32*i +: 32];
        c    = {1'b0, shadow_cfg.contrast_scale};
        fidx = {16'd0, shadow_cfg.freq_index};
        if (fld[1] != 32'd0)
        begin
            quot = ({32'd0, fld[0]} * {32'd0, c}) / {32'd0, fld[1]};
            d    = quot[31:0] - c;
        end
        else
            d = c;
        r.new_sum_contrast     = fld[2] + d;
        r.new_sum_first_moment = fld[3] + fidx * d;
        s2   = fld[4];
        s3   = fld[5];
        peak = offset_mag(r.new_sum_first_moment);
        if (shadow_cfg.method == METHOD_SECOND)
        begin
            s2   = s2 + {1'b0, shadow_cfg.freq_offset_square} * d;
            dv   = offset_mag(s2);
            peak = (dv > peak) ? dv : peak;
        end
        else if (shadow_cfg.method inside {METHOD_MEAN_DEV, METHOD_SPLIT} &&
                 shadow_cfg.earlier_pass_valid)
        begin
            p    = unbiased(fld[6]);
            f    = unbiased(fld[7]);
            g    = (p != 0) ? (f * longint'({32'd0, c})) / p : 0;
            a    = longint'({32'd0, fidx}) * longint'({32'd0, c});
            dev  = (a >= g) ? 64'(a - g) : 64'(g - a);
            s2   = s2 + weighted_term(dev, d, c);
            dv   = offset_mag(s2);
            peak = (dv > peak) ? dv : peak;
            if (shadow_cfg.method == METHOD_SPLIT)
            begin
                m = unbiased(fld[8]);
                if (m < 0)
                    split = dev + 64'(-m);
                else if (dev >= 64'(m))
                    split = dev - 64'(m);
                else
                    split = 64'(m) - dev;
                s3   = s3 + weighted_term(split, d, c);
                dv   = offset_mag(s3);
                peak = (dv > peak) ? dv : peak;
            end
        end
        r.new_sum_third  = s2;
        r.new_sum_fourth = s3;
        r.peak_deviation = peak;
        return r;
    endfunction

    assign pending = wr_cnt - rd_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_cfg <= '{contrast_scale: 31'd1, default: '0};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CONTRAST_SCALE:     shadow_cfg.contrast_scale     <= cfg_wdata;
                CFG_FREQ_INDEX:         shadow_cfg.freq_index         <= cfg_wdata[15:0];
                CFG_FREQ_OFFSET_SQUARE: shadow_cfg.freq_offset_square <= cfg_wdata;
                CFG_METHOD:             shadow_cfg.method             <= cfg_wdata[1:0];
                CFG_EARLIER_PASS_VALID: shadow_cfg.earlier_pass_valid <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input and output requests are sampled at the same edge
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                exp_mem[wr_cnt % EXP_DEPTH] = predict_sums(s_tdata);
                wr_cnt++;
            end
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                        m_tdata[127:96], m_tdata[159:128]};
                if (rd_cnt == wr_cnt)
                begin
                    $error("result with no pixel outstanding: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = exp_mem[rd_cnt % EXP_DEPTH];
                    rd_cnt++;
                    if (got.new_sum_contrast !== want.new_sum_contrast)
                    begin
                        $error("new_sum_contrast exp %h got %h",
                               want.new_sum_contrast, got.new_sum_contrast);
                        errors++;
                    end
                    if (got.new_sum_first_moment !== want.new_sum_first_moment)
                    begin
                        $error("new_sum_first_moment exp %h got %h",
                               want.new_sum_first_moment, got.new_sum_first_moment);
                        errors++;
                    end
                    if (got.new_sum_third !== want.new_sum_third)
                    begin
                        $error("new_sum_third exp %h got %h",
                               want.new_sum_third, got.new_sum_third);
                        errors++;
                    end
                    if (got.new_sum_fourth !== want.new_sum_fourth)
                    begin
                        $error("new_sum_fourth exp %h got %h",
                               want.new_sum_fourth, got.new_sum_fourth);
                        errors++;
                    end
                    if (got.peak_deviation !== want.peak_deviation)
                    begin
                        $error("peak_deviation exp %h got %h",
                               want.peak_deviation, got.peak_deviation);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top: clock, reset, pixel stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb;
    import odmr_pma_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PIPE_DRAIN  = 400;   // well past the pipeline latency
    localparam int LONG_HOLD   = 600;   // receiver hold-off that backs up the pipeline

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;       // pixel fields, on_count lowest
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;            // result sums, new_sum_contrast lowest
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = CFG_CONTRAST_SCALE;
    logic [30:0]  cfg_wdata = '0;

    int errors;
    int pending;
    int cycles = 0;
    int idle_pct = 0;     // sender gap chance, percent per cycle
    int stall_pct = 0;    // receiver stall chance, percent per cycle
    int hold_asked = 0;   // bumped by stimulus to start a long hold-off
    int hold_taken = 0;
    int hold_left = 0;

    always #6 clk = ~clk;

    odmr_pixel_moment_accumulate i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    odmr_pma_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_taken != hold_asked)
        begin
            hold_taken <= hold_asked;
            hold_left  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Register writes; cfg_we stays high across a burst and drops once after it.
    task automatic write_regs(input logic [30:0] scale, input logic [30:0] fidx,
                              input logic [30:0] fsq, input logic [30:0] meth,
                              input logic [30:0] prior_ok);
        logic [30:0] vals [5];
        vals = '{scale, fidx, fsq, meth, prior_ok};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        // index past the last register must be ignored
        cfg_index <= 3'd7;
        cfg_wdata <= 31'h7fff_ffff;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [31:0] f [9]);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        for (int i = 0; i < 9; i++)
            s_tdata[32*i +: 32] <= f[i];
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_count();
        case ($urandom_range(5))
            0:       return $urandom_range(16);
            1:       return $urandom_range(4000);
            2:       return 32'hffff_ffff - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // Biased sums: half anywhere, otherwise near the bias point or exactly at it
    function automatic logic [31:0] rand_biased();
        case ($urandom_range(5))
            0:       return BIAS;
            1:       return BIAS + $urandom_range(2000) - 1000;
            2:       return BIAS + $urandom_range(2_000_000) - 1_000_000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random;
        logic [31:0] f [9];
        f[0] = rand_count();
        f[1] = ($urandom_range(9) == 0) ? 32'd0 : rand_count();
        // on close to off gives small contrast, for up to a third of pixels
        if ($urandom_range(2) == 0 && f[1] > 32'd10)
            f[0] = f[1] + $urandom_range(20) - 10;
        for (int i = 2; i < 9; i++)
            f[i] = rand_biased();
        send_pixel(f);
    endtask

    task automatic send_directed;
        logic [31:0] x [9];
        logic [31:0] cases [][9];
        cases = '{
            '{32'd0, 32'd0, BIAS, BIAS, BIAS, BIAS, BIAS, BIAS, BIAS},
            '{32'd100, 32'd0, BIAS, BIAS, BIAS, BIAS, 32'd0, 32'd0, 32'd0},
            '{32'hffffffff, 32'd1, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
            '{32'hffffffff, 32'hffffffff, 32'd0, 32'd0, 32'd0, 32'd0,
              32'd0, 32'hffffffff, 32'd0},
            '{32'd0, 32'hffffffff, 32'd0, 32'd0, 32'd0, 32'd0,
              32'hffffffff, 32'd0, 32'hffffffff},
            '{32'd1, 32'd1, BIAS, BIAS, BIAS, BIAS, BIAS + 1, 32'd0, BIAS - 1},
            '{32'd1, 32'd2, BIAS, BIAS, BIAS, BIAS, BIAS - 1, 32'hffffffff, BIAS + 1},
            '{32'd3, 32'd2, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              BIAS + 7, BIAS + 300, BIAS},
            '{32'h5555aaaa, 32'haaaa5555, 32'haaaa5555, 32'h5555aaaa, 32'h0f0f0f0f,
              32'hf0f0f0f0, 32'h3c3c3c3c, 32'hc3c3c3c3, 32'h12345678}
        };
        foreach (cases[k])
        begin
            x = cases[k];
            send_pixel(x);
        end
    endtask

    initial
    begin
        logic [30:0] scale, fsq;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration first, then the extremes with every method
        send_directed();
        drain();
        for (int meth = METHOD_COG; meth <= METHOD_SPLIT; meth++)
        begin
            write_regs(31'h7fff_ffff, 31'hffff, 31'h4000_0000, 31'(meth), 31'd1);
            send_directed();
            drain();
        end
        write_regs(31'd1, 31'd0, 31'h7fff_ffff, 31'(METHOD_SPLIT), 31'd1);
        send_directed();
        drain();
        // zero scale, no earlier pass
        write_regs(31'd0, 31'd37, 31'd1369, 31'(METHOD_SPLIT), 31'd0);
        send_directed();
        drain();

        // Random phases: idling mode cycles every four phases
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            case ($urandom_range(3))
                0:       scale = 31'(32'h7fff_ffff - $urandom_range(3));
                1:       scale = 31'($urandom_range(1000, 1));
                default: scale = 31'($urandom_range(32'h7fff_ffff, 1));
            endcase
            fsq = ($urandom_range(3) == 0) ? 31'($urandom)
                                           : 31'($urandom_range(32'h4000_0000));
            write_regs(scale, 31'($urandom), fsq, 31'(ph % 4), 31'($urandom_range(3) != 0));
            if (ph == 4)
                hold_asked++;
            // the held phase sends more pixels than the pipeline holds
            for (int n = 0; n < ((ph == 4) ? 240 : 64); n++)
                send_random();
            drain();
        end

        repeat (PIPE_DRAIN) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
